// File: rtl/core/sspm_pkg.sv
// ----------------------------------------------------------------------------
// sspm_pkg
// Shared constants and types for the selective 3x3 salt-and-pepper median
// filter: default geometry limits, register indexes and the result word.
// ----------------------------------------------------------------------------
package sspm_pkg;

   // default frame limits
   localparam int unsigned MAX_WIDTH_DEF  = 1024;
   localparam int unsigned MAX_HEIGHT_DEF = 1024;

   // register port geometry
   localparam int unsigned CSR_DATA_W = 11;
   localparam int unsigned CSR_ADDR_W = 2;

   // pixel and line ring geometry
   localparam int unsigned PIX_W      = 8;
   localparam int unsigned RING_SLOTS = 4;
   localparam int unsigned SLOT_W     = 2;
   localparam int unsigned WIN_SIZE   = 9;

   // impulse level reset values
   localparam logic [PIX_W-1:0] LOW_LEVEL_RST  = 8'd0;
   localparam logic [PIX_W-1:0] HIGH_LEVEL_RST = 8'd255;

   // register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_LOW_LEVEL    = 2'd2,
      CSR_HIGH_LEVEL   = 2'd3
   } csr_index_type;

   // one result word
   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             replaced;
      logic             last;
   } rsp_word_type;

endpackage

// File: rtl/core/salt_pepper_median_filter_core.sv
// ----------------------------------------------------------------------------
// salt_pepper_median_filter_core
// Selective 3x3 median filter: impulse pixels are replaced in place by the
// median of their clipped window, held in a ring of four line memories.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle on both sides while the result queue is not
// full; a pixel is released once the pixel right-below it has arrived, drain
// words flush the frame tail. Path: a released pixel is read from the line
// memories into stage 1, then its window median is pushed into a 2-entry
// queue that drives the result port.
// Reset: synchronous; clears counters and queue, restores default geometry and
// impulse levels. The line memories are not cleared.
module salt_pepper_median_filter_core
   import sspm_pkg::*;
#(
   parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  logic [PIX_W-1:0]      req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_pixel_out,
   output logic                  rsp_was_replaced,
   output logic                  rsp_frame_end,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned CB  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned RB  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int unsigned WB  = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HB  = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned CWW = (WB > CSR_DATA_W) ? WB : CSR_DATA_W;
   localparam int unsigned CWH = (HB > CSR_DATA_W) ? HB : CSR_DATA_W;
   localparam logic [WB-1:0] WIDTH_RST  = WB'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
   localparam logic [HB-1:0] HEIGHT_RST = HB'((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [WB-1:0]    width_ff;
   logic [HB-1:0]    height_ff;
   logic [PIX_W-1:0] low_lvl_ff;
   logic [PIX_W-1:0] high_lvl_ff;
   logic [CWW-1:0]   cfg_w_ext;
   logic [CWH-1:0]   cfg_h_ext;
   logic [WB-1:0]    width_in;
   logic [HB-1:0]    height_in;

   // clamp sizes to 1..max
   always_comb begin
      cfg_w_ext = CWW'(csr_wdata);
      cfg_h_ext = CWH'(csr_wdata);
      if (cfg_w_ext == '0) begin
         width_in = WB'(1);
      end else if (cfg_w_ext > CWW'(MAX_WIDTH)) begin
         width_in = WB'(MAX_WIDTH);
      end else begin
         width_in = WB'(cfg_w_ext);
      end
      if (cfg_h_ext == '0) begin
         height_in = HB'(1);
      end else if (cfg_h_ext > CWH'(MAX_HEIGHT)) begin
         height_in = HB'(MAX_HEIGHT);
      end else begin
         height_in = HB'(cfg_h_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= WIDTH_RST;
         height_ff   <= HEIGHT_RST;
         low_lvl_ff  <= LOW_LEVEL_RST;
         high_lvl_ff <= HIGH_LEVEL_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_IMAGE_WIDTH:  width_ff    <= width_in;
            CSR_IMAGE_HEIGHT: height_ff   <= height_in;
            CSR_LOW_LEVEL:    low_lvl_ff  <= csr_wdata[PIX_W-1:0];
            CSR_HIGH_LEVEL:   high_lvl_ff <= csr_wdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // handshake and pipeline advance
   // ------------------------------------------------------------------
   logic              adv;
   logic              accept;
   logic              pix;
   logic              s1_valid_ff;
   logic [1:0]        q_cnt_ff;
   logic              q_full;

   assign q_full    = (q_cnt_ff == 2'd2);
   assign adv       = !s1_valid_ff || !q_full;
   assign req_ready = adv;
   assign accept    = req_valid && adv;
   assign pix       = !req_command;

   // ------------------------------------------------------------------
   // raster counters
   // ------------------------------------------------------------------
   logic [CB-1:0]     in_col_ff,  in_col_in;
   logic [RB-1:0]     in_row_ff,  in_row_in;
   logic [SLOT_W-1:0] in_slot_ff, in_slot_in;
   logic [CB-1:0]     out_col_ff,  out_col_in;
   logic [RB-1:0]     out_row_ff,  out_row_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic [1:0]        ahead_ff,   ahead_in;
   logic [1:0]        ahead_mid;
   logic              in_end_col, in_end_row;
   logic              out_end_col, out_end_row;
   logic [WB-1:0]     nx;
   logic [HB-1:0]     ny;
   logic              out_ready;
   logic              issue;
   logic              has_up, has_dn, has_lft, has_rgt;
   logic [CB-1:0]     rd_col1;

   always_comb begin
      // input side advance
      in_end_col = (WB'(in_col_ff) + WB'(1)) >= width_ff;
      in_end_row = (HB'(in_row_ff) + HB'(1)) >= height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      in_slot_in = in_slot_ff;
      ahead_mid  = ahead_ff;
      if (pix) begin
         if (in_end_col) begin
            in_col_in  = '0;
            in_slot_in = in_slot_ff + SLOT_W'(1);
            if (in_end_row) begin
               in_row_in = '0;
               if (ahead_ff != 2'd3) begin
                  ahead_mid = ahead_ff + 2'd1;
               end
            end else begin
               in_row_in = in_row_ff + RB'(1);
            end
         end else begin
            in_col_in = in_col_ff + CB'(1);
         end
      end

      // release check: window of the next output pixel complete
      out_end_col = (WB'(out_col_ff) + WB'(1)) >= width_ff;
      out_end_row = (HB'(out_row_ff) + HB'(1)) >= height_ff;
      nx = out_end_col ? (width_ff - WB'(1)) : (WB'(out_col_ff) + WB'(1));
      ny = out_end_row ? (height_ff - HB'(1)) : (HB'(out_row_ff) + HB'(1));
      out_ready = (ahead_mid != 2'd0) || (HB'(in_row_in) > ny) ||
                  ((HB'(in_row_in) == ny) && (WB'(in_col_in) > nx));
      issue = accept && out_ready;

      // output side advance
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;
      ahead_in    = ahead_mid;
      if (issue) begin
         if (out_end_col) begin
            out_col_in  = '0;
            out_slot_in = out_slot_ff + SLOT_W'(1);
            if (out_end_row) begin
               out_row_in = '0;
               if (ahead_mid != 2'd0) begin
                  ahead_in = ahead_mid - 2'd1;
               end
            end else begin
               out_row_in = out_row_ff + RB'(1);
            end
         end else begin
            out_col_in = out_col_ff + CB'(1);
         end
      end

      // window clipping of the issued pixel
      has_up  = (out_row_ff != '0);
      has_dn  = !out_end_row;
      has_lft = (out_col_ff != '0);
      has_rgt = !out_end_col;
      rd_col1 = has_rgt ? CB'(WB'(out_col_ff) + WB'(1)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
         ahead_ff    <= '0;
      end else if (accept) begin
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
         ahead_ff    <= ahead_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1 job registers and forwarding
   // ------------------------------------------------------------------
   logic [CB-1:0]     s1_col_ff, s1_col1_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic              s1_up_ff, s1_dn_ff, s1_lft_ff, s1_rgt_ff, s1_last_ff;
   logic              fin_v_ff;
   logic [SLOT_W-1:0] fin_slot_ff;
   logic [CB-1:0]     fin_col_ff;
   logic [PIX_W-1:0]  fin_data_ff;
   logic              fwb_v_ff;
   logic [SLOT_W-1:0] fwb_slot_ff;
   logic [CB-1:0]     fwb_col_ff;
   logic [PIX_W-1:0]  fwb_data_ff;
   logic [PIX_W-1:0]  lft_ff [3];
   logic [PIX_W-1:0]  rd_a [RING_SLOTS];
   logic [PIX_W-1:0]  rd_b [RING_SLOTS];
   logic              in_we;
   logic              wb_we;
   logic [PIX_W-1:0]  result;
   logic              replaced;

   assign in_we = accept && pix;

   // ------------------------------------------------------------------
   // line ring: one memory per slot, input write wins a same-slot clash
   // ------------------------------------------------------------------
   for (genvar g = 0; g < RING_SLOTS; g++) begin : g_slot
      logic [PIX_W-1:0] row_mem [MAX_WIDTH];
      logic [PIX_W-1:0] rd_a_ff;
      logic [PIX_W-1:0] rd_b_ff;
      always_ff @(posedge clock) begin
         if (in_we && (in_slot_ff == SLOT_W'(g))) begin
            row_mem[in_col_ff] <= req_pixel_in;
         end else if (wb_we && (s1_slot_ff == SLOT_W'(g))) begin
            row_mem[s1_col_ff] <= result;
         end
         if (adv) begin
            rd_a_ff <= row_mem[out_col_ff];
            rd_b_ff <= row_mem[rd_col1];
         end
      end
      assign rd_a[g] = rd_a_ff;
      assign rd_b[g] = rd_b_ff;
   end

   // capture job and same-edge writes
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fin_v_ff    <= 1'b0;
         fwb_v_ff    <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= issue;
         fin_v_ff    <= in_we;
         fwb_v_ff    <= wb_we;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_col_ff   <= out_col_ff;
         s1_col1_ff  <= rd_col1;
         s1_slot_ff  <= out_slot_ff;
         s1_up_ff    <= has_up;
         s1_dn_ff    <= has_dn;
         s1_lft_ff   <= has_lft;
         s1_rgt_ff   <= has_rgt;
         s1_last_ff  <= out_end_col && out_end_row;
         fin_slot_ff <= in_slot_ff;
         fin_col_ff  <= in_col_ff;
         fin_data_ff <= req_pixel_in;
         fwb_slot_ff <= s1_slot_ff;
         fwb_col_ff  <= s1_col_ff;
         fwb_data_ff <= result;
      end
   end

   // ------------------------------------------------------------------
   // window assembly and median by rank
   // ------------------------------------------------------------------
   logic [SLOT_W-1:0]     role_slot [3];
   logic [PIX_W-1:0]      cen_v [3];
   logic [PIX_W-1:0]      rgt_v [3];
   logic                  row_ok [3];
   logic                  col_ok [3];
   logic [PIX_W:0]        win [WIN_SIZE];
   logic [3:0]            win_cnt;
   logic [3:0]            rank;
   logic [PIX_W-1:0]      median;

   always_comb begin
      role_slot[0] = s1_slot_ff - SLOT_W'(1);
      role_slot[1] = s1_slot_ff;
      role_slot[2] = s1_slot_ff + SLOT_W'(1);
      row_ok[0] = s1_up_ff;
      row_ok[1] = 1'b1;
      row_ok[2] = s1_dn_ff;
      col_ok[0] = s1_lft_ff;
      col_ok[1] = 1'b1;
      col_ok[2] = s1_rgt_ff;

      // forward writes that landed on the read edge
      for (int k = 0; k < 3; k++) begin
         cen_v[k] = rd_a[role_slot[k]];
         rgt_v[k] = rd_b[role_slot[k]];
         if (fwb_v_ff && (fwb_slot_ff == role_slot[k])) begin
            if (fwb_col_ff == s1_col_ff) cen_v[k] = fwb_data_ff;
            if (fwb_col_ff == s1_col1_ff) rgt_v[k] = fwb_data_ff;
         end
         if (fin_v_ff && (fin_slot_ff == role_slot[k])) begin
            if (fin_col_ff == s1_col_ff) cen_v[k] = fin_data_ff;
            if (fin_col_ff == s1_col1_ff) rgt_v[k] = fin_data_ff;
         end
      end

      // absent pixels sort above all present ones
      win_cnt = '0;
      for (int r = 0; r < 3; r++) begin
         win[r*3]     = (row_ok[r] && col_ok[0]) ? {1'b0, lft_ff[r]} : {1'b1, 8'h00};
         win[r*3 + 1] = row_ok[r] ? {1'b0, cen_v[r]} : {1'b1, 8'h00};
         win[r*3 + 2] = (row_ok[r] && col_ok[2]) ? {1'b0, rgt_v[r]} : {1'b1, 8'h00};
         for (int c = 0; c < 3; c++) begin
            win_cnt = win_cnt + 4'(row_ok[r] && col_ok[c]);
         end
      end

      // pick the element whose unique rank is count/2
      median = '0;
      for (int i = 0; i < WIN_SIZE; i++) begin
         rank = '0;
         for (int j = 0; j < WIN_SIZE; j++) begin
            if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
               rank = rank + 4'd1;
            end
         end
         if (rank == (win_cnt >> 1)) begin
            median = win[i][PIX_W-1:0];
         end
      end

      replaced = (cen_v[1] == low_lvl_ff) || (cen_v[1] == high_lvl_ff);
      result   = replaced ? median : cen_v[1];
      wb_we    = adv && s1_valid_ff && replaced &&
                 !(in_we && (in_slot_ff == s1_slot_ff));
   end

   // hold the finished column as the next job's left column
   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         lft_ff[0] <= cen_v[0];
         lft_ff[1] <= result;
         lft_ff[2] <= cen_v[2];
      end
   end

   // ------------------------------------------------------------------
   // result queue, two words
   // ------------------------------------------------------------------
   rsp_word_type q_ff [2];
   logic         q_wr_ff, q_rd_ff;
   logic         push, pop;

   assign push = adv && s1_valid_ff;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
         q_wr_ff  <= 1'b0;
         q_rd_ff  <= 1'b0;
      end else begin
         if (push) q_wr_ff <= !q_wr_ff;
         if (pop)  q_rd_ff <= !q_rd_ff;
         q_cnt_ff <= q_cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[q_wr_ff] <= '{pixel: result, replaced: replaced, last: s1_last_ff};
      end
   end

   assign rsp_valid        = (q_cnt_ff != 2'd0);
   assign rsp_pixel_out    = q_ff[q_rd_ff].pixel;
   assign rsp_was_replaced = q_ff[q_rd_ff].replaced;
   assign rsp_frame_end    = q_ff[q_rd_ff].last;

`ifndef ASSERT_OFF
   // queue never overfills
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff != 2'd3) else $error("result queue count out of range");

   // a push never meets a full queue without a pop
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (push && q_full) |-> pop) else $error("result queue overrun");

   // a stalled job holds its place
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !adv) |=> (s1_valid_ff && $stable(s1_col_ff) &&
                                 $stable(s1_slot_ff))) else $error("stage 1 job lost");
`endif

endmodule
